>>> hdl/ddo_pkg.sv
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAST  = ((CORDIC_STEPS < 24) ? CORDIC_STEPS : 24) - 1;
    localparam logic signed [17:0] WRAP_LIMIT = 18'sd30000;

    localparam int MUL_LAST = 17;
    localparam int DIV_LAST = 63;

    localparam logic [2:0] CFG_METERS_PER_TICK   = 3'd0;
    localparam logic [2:0] CFG_WHEEL_BASE        = 3'd1;
    localparam logic [2:0] CFG_START_HEADING     = 3'd2;
    localparam logic [2:0] CFG_ARC_MODE          = 3'd3;
    localparam logic [2:0] CFG_START_LEFT_COUNT  = 3'd4;
    localparam logic [2:0] CFG_START_RIGHT_COUNT = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_HRED, S_HFOLD, S_MUL, S_MTAKE, S_TRAV, S_TDIV, S_DIV,
        S_TURN, S_CSET, S_CORD, S_CFIN, S_RTAKE, S_POS, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_DL, MOP_DR, MOP_NUM, MOP_RX, MOP_RY, MOP_SX, MOP_SY
    } t_mop;

    function automatic logic [30:0] atan_q30(input logic [5:0] i);
        logic [30:0] v;
        case (i)
            6'd0:  v = 31'd843314856;
            6'd1:  v = 31'd497837829;
            6'd2:  v = 31'd263043836;
            6'd3:  v = 31'd133525158;
            6'd4:  v = 31'd67021686;
            6'd5:  v = 31'd33543515;
            6'd6:  v = 31'd16775850;
            6'd7:  v = 31'd8388437;
            6'd8:  v = 31'd4194282;
            6'd9:  v = 31'd2097149;
            6'd10: v = 31'd1048575;
            6'd11: v = 31'd524287;
            6'd12: v = 31'd262143;
            6'd13: v = 31'd131071;
            6'd14: v = 31'd65535;
            6'd15: v = 31'd32767;
            6'd16: v = 31'd16383;
            6'd17: v = 31'd8191;
            6'd18: v = 31'd4095;
            6'd19: v = 31'd2047;
            6'd20: v = 31'd1023;
            6'd21: v = 31'd511;
            6'd22: v = 31'd255;
            6'd23: v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/differential_drive_odometry.sv
// channel  | direction | handshake               | payload
// input    | in        | i_in_valid / o_in_stall | left_count, right_count, gyro_angle
// result   | out       | o_out_valid / i_out_stall | pos, heading, distance, turn, totals, steps
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one transaction at a time; the length of a straight or an arc update is set by the
// shift-add multiplier (four or five products), the restoring divider (once or twice,
// skipped for the turn angle when the wheel base is zero) and the 16-step cordic
// (once or twice)
// reset (synchronous, active low) clears the state and loads register defaults
// a finished result waits in the output register; the core waits only if the
// previous result is still stalled when the next one is ready
module differential_drive_odometry (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [15:0]         i_left_count,
    input  logic [15:0]         i_right_count,
    input  logic signed [15:0]  i_gyro_angle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [47:0]  o_pos_x,
    output logic signed [47:0]  o_pos_y,
    output logic signed [15:0]  o_heading,
    output logic signed [31:0]  o_step_distance,
    output logic signed [31:0]  o_turn_angle,
    output logic signed [47:0]  o_left_total,
    output logic signed [47:0]  o_right_total,
    output logic signed [16:0]  o_left_step,
    output logic signed [16:0]  o_right_step,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ddo_pkg::*;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [20:0] r;
        t = {v[33], v} + 35'sd8192;
        r = t[34:14];
        if (r > 21'sd65536) return 18'sd65536;
        if (r < -21'sd65536) return -18'sd65536;
        return r[17:0];
    endfunction

    // state and configuration
    t_state r_state, n_state;
    t_mop   r_mop, n_mop;
    logic [31:0] r_mpt, n_mpt;
    logic [23:0] r_wb, n_wb;
    logic signed [16:0] r_sh, n_sh;
    logic r_arc, n_arc;
    logic [15:0] r_last_l, n_last_l, r_last_r, n_last_r;
    logic signed [15:0] r_prev, n_prev;
    logic signed [47:0] r_ltrav, n_ltrav, r_rtrav, n_rtrav, r_x, n_x, r_y, n_y;

    // per-transaction working registers
    logic signed [16:0] r_dl, n_dl, r_dr, n_dr;
    logic r_hneg, n_hneg;
    logic [16:0] r_hmag, n_hmag;
    logic signed [15:0] r_h, n_h;
    logic [41:0] r_ma, n_ma;
    logic [59:0] r_mp, n_mp;
    logic r_mneg, n_mneg;
    logic [5:0] r_cnt, n_cnt;
    logic signed [32:0] r_distl, n_distl, r_distr, n_distr, r_mean, n_mean;
    logic signed [31:0] r_turn, n_turn;
    logic [63:0] r_dvd, n_dvd;
    logic [24:0] r_dsr, n_dsr, r_rem, n_rem;
    logic [41:0] r_quo, n_quo;
    logic r_sticky, n_sticky, r_dneg, n_dneg, r_darc, n_darc;
    logic r_pass, n_pass, r_cfold, n_cfold, r_csneg, n_csneg;
    logic signed [33:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [32:0] r_cz, n_cz;
    logic signed [17:0] r_sn, n_sn, r_cs, n_cs, r_sp, n_sp, r_cp, n_cp;
    logic signed [44:0] r_dx, n_dx, r_dy, n_dy;

    // output register
    logic r_ovalid, n_ovalid;
    logic signed [47:0] r_o_x, n_o_x, r_o_y, n_o_y, r_o_lt, n_o_lt, r_o_rt, n_o_rt;
    logic signed [15:0] r_o_h, n_o_h;
    logic signed [31:0] r_o_sd, n_o_sd, r_o_ta, n_o_ta;
    logic signed [16:0] r_o_ls, n_o_ls, r_o_rs, n_o_rs;

    // combinational helpers
    logic signed [17:0] d_l, d_r, h_raw, h_sgn, h_fold;
    logic [42:0] m_sum;
    logic signed [60:0] m_sgn;
    logic signed [44:0] m_res;
    logic [25:0] dv_t;
    logic dv_ge;
    logic signed [48:0] t_diff;
    logic signed [15:0] c_ang, c_abs, c_red;
    logic [37:0] c_zp;
    logic signed [33:0] c_dx, c_dy;
    logic signed [32:0] c_at;
    logic signed [17:0] c_s, c_c, c_sc, c_ss;
    logic signed [17:0] a_sum, a_diff;
    logic signed [18:0] s_d, c_d;
    logic signed [33:0] mean_sum;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_pos_x = r_o_x;
    assign o_pos_y = r_o_y;
    assign o_heading = r_o_h;
    assign o_step_distance = r_o_sd;
    assign o_turn_angle = r_o_ta;
    assign o_left_total = r_o_lt;
    assign o_right_total = r_o_rt;
    assign o_left_step = r_o_ls;
    assign o_right_step = r_o_rs;

    always_comb begin
        // tick deltas with rollover unwrap
        d_l = $signed({2'b0, i_left_count}) - $signed({2'b0, r_last_l});
        if (d_l > WRAP_LIMIT) d_l = d_l - 18'sd65536;
        else if (d_l < -WRAP_LIMIT) d_l = d_l + 18'sd65536;
        d_r = $signed({2'b0, i_right_count}) - $signed({2'b0, r_last_r});
        if (d_r > WRAP_LIMIT) d_r = d_r - 18'sd65536;
        else if (d_r < -WRAP_LIMIT) d_r = d_r + 18'sd65536;
        h_raw = {{2{i_gyro_angle[15]}}, i_gyro_angle} - {r_sh[16], r_sh};

        // heading fold to +/-18000
        h_sgn = r_hneg ? -$signed({1'b0, r_hmag}) : $signed({1'b0, r_hmag});
        h_fold = h_sgn;
        if (h_sgn > 18'sd18000) h_fold = h_sgn - 18'sd36000;
        else if (h_sgn < -18'sd18000) h_fold = h_sgn + 18'sd36000;

        // shift-add multiplier step and signed, floored result
        m_sum = {1'b0, r_mp[59:18]} + (r_mp[0] ? {1'b0, r_ma} : 43'd0);
        m_sgn = r_mneg ? -$signed({1'b0, r_mp}) : $signed({1'b0, r_mp});
        m_res = m_sgn[60:16];

        // restoring divider step
        dv_t  = {r_rem, r_dvd[63]};
        dv_ge = (dv_t >= {1'b0, r_dsr});

        t_diff = {r_rtrav[47], r_rtrav} - {r_ltrav[47], r_ltrav};

        // cordic set-up, step and finish
        c_ang = r_pass ? r_prev : r_h;
        c_abs = c_ang[15] ? -c_ang : c_ang;
        c_red = (c_abs > 16'sd9000) ? (16'sd18000 - c_abs) : c_abs;
        c_zp  = c_red[13:0] * 24'd11993811;
        c_dx  = r_cy >>> r_cnt[4:0];
        c_dy  = r_cx >>> r_cnt[4:0];
        c_at  = $signed({2'b0, atan_q30(r_cnt)});
        c_s   = to_q16(r_cy);
        c_c   = to_q16(r_cx);
        c_sc  = r_cfold ? -c_c : c_c;
        c_ss  = r_csneg ? -c_s : c_s;

        a_sum  = {r_dr[16], r_dr} + {r_dl[16], r_dl};
        a_diff = {r_dr[16], r_dr} - {r_dl[16], r_dl};
        s_d = {r_sn[17], r_sn} - {r_sp[17], r_sp};
        c_d = {r_cs[17], r_cs} - {r_cp[17], r_cp};
        mean_sum = {r_distl[32], r_distl} + {r_distr[32], r_distr};
    end

    always_comb begin
        n_state = r_state;  n_mop = r_mop;
        n_mpt = r_mpt;  n_wb = r_wb;  n_sh = r_sh;  n_arc = r_arc;
        n_last_l = r_last_l;  n_last_r = r_last_r;  n_prev = r_prev;
        n_ltrav = r_ltrav;  n_rtrav = r_rtrav;  n_x = r_x;  n_y = r_y;
        n_dl = r_dl;  n_dr = r_dr;  n_hneg = r_hneg;  n_hmag = r_hmag;  n_h = r_h;
        n_ma = r_ma;  n_mp = r_mp;  n_mneg = r_mneg;  n_cnt = r_cnt;
        n_distl = r_distl;  n_distr = r_distr;  n_mean = r_mean;  n_turn = r_turn;
        n_dvd = r_dvd;  n_dsr = r_dsr;  n_rem = r_rem;  n_quo = r_quo;
        n_sticky = r_sticky;  n_dneg = r_dneg;  n_darc = r_darc;
        n_pass = r_pass;  n_cfold = r_cfold;  n_csneg = r_csneg;
        n_cx = r_cx;  n_cy = r_cy;  n_cz = r_cz;
        n_sn = r_sn;  n_cs = r_cs;  n_sp = r_sp;  n_cp = r_cp;
        n_dx = r_dx;  n_dy = r_dy;
        n_ovalid = r_ovalid && i_out_stall;
        n_o_x = r_o_x;  n_o_y = r_o_y;  n_o_h = r_o_h;  n_o_sd = r_o_sd;
        n_o_ta = r_o_ta;  n_o_lt = r_o_lt;  n_o_rt = r_o_rt;
        n_o_ls = r_o_ls;  n_o_rs = r_o_rs;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_dl = d_l[16:0];
                    n_dr = d_r[16:0];
                    n_last_l = i_left_count;
                    n_last_r = i_right_count;
                    n_hneg = h_raw[17];
                    n_hmag = h_raw[17] ? 17'(-h_raw) : h_raw[16:0];
                    n_state = S_HRED;
                end
            end
            S_HRED: begin
                // truncating remainder by 36000 on the magnitude
                if (r_hmag >= 17'd36000) begin
                    n_hmag = r_hmag - 17'd36000;
                end else begin
                    n_state = S_HFOLD;
                end
            end
            S_HFOLD: begin
                n_h = h_fold[15:0];
                n_ma = {10'd0, r_mpt};
                n_mp = {42'd0, (r_dl[16] ? 18'(-{r_dl[16], r_dl}) : {1'b0, r_dl})};
                n_mneg = r_dl[16];
                n_mop = MOP_DL;
                n_cnt = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_mp = {m_sum, r_mp[17:1]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(MUL_LAST)) n_state = S_MTAKE;
            end
            S_MTAKE: begin
                n_cnt = '0;
                case (r_mop)
                    MOP_DL: begin
                        n_distl = m_res[32:0];
                        n_ma = {10'd0, r_mpt};
                        n_mp = {42'd0, (r_dr[16] ? 18'(-{r_dr[16], r_dr}) : {1'b0, r_dr})};
                        n_mneg = r_dr[16];
                        n_mop = MOP_DR;
                        n_state = S_MUL;
                    end
                    MOP_DR: begin
                        n_distr = m_res[32:0];
                        n_state = S_TRAV;
                    end
                    MOP_NUM: begin
                        n_dvd = {23'd0, r_mp[40:0]};
                        n_dsr = {6'd0, (a_diff[17] ? 18'(-a_diff) : a_diff), 1'b0};
                        n_dneg = r_mneg ^ a_diff[17];
                        n_rem = '0;
                        n_quo = '0;
                        n_sticky = 1'b0;
                        n_darc = 1'b1;
                        n_state = S_DIV;
                    end
                    MOP_RX: begin
                        n_dx = m_res;
                        n_ma = r_quo;
                        n_mp = {42'd0, (c_d[18] ? 18'(-c_d) : c_d[17:0])};
                        n_mneg = r_dneg ^ c_d[18];
                        n_mop = MOP_RY;
                        n_state = S_MUL;
                    end
                    MOP_SX: begin
                        n_dx = m_res;
                        n_ma = {9'd0, (r_mean[32] ? 33'(-r_mean) : r_mean)};
                        n_mp = {42'd0, (r_sn[17] ? 18'(-r_sn) : r_sn)};
                        n_mneg = r_mean[32] ^ r_sn[17];
                        n_mop = MOP_SY;
                        n_state = S_MUL;
                    end
                    default: begin
                        // second coordinate of either update
                        n_dy = m_res;
                        n_state = S_POS;
                    end
                endcase
            end
            S_TRAV: begin
                n_ltrav = sat48({r_ltrav[47], r_ltrav} + 49'(r_distl));
                n_rtrav = sat48({r_rtrav[47], r_rtrav} + 49'(r_distr));
                n_mean = mean_sum[33:1];
                n_state = S_TDIV;
            end
            S_TDIV: begin
                n_cnt = '0;
                n_pass = 1'b0;
                if (r_wb == 24'd0) begin
                    n_turn = '0;
                    n_state = S_CSET;
                end else begin
                    n_dvd = {(t_diff[48] ? 48'(-t_diff) : t_diff[47:0]), 16'd0};
                    n_dsr = {r_wb, 1'b0};
                    n_dneg = t_diff[48];
                    n_rem = '0;
                    n_quo = '0;
                    n_sticky = 1'b0;
                    n_darc = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = dv_ge ? 25'(dv_t - {1'b0, r_dsr}) : dv_t[24:0];
                n_dvd = {r_dvd[62:0], 1'b0};
                n_quo = {r_quo[40:0], dv_ge};
                n_sticky = r_sticky | r_quo[41];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_LAST)) n_state = r_darc ? S_RTAKE : S_TURN;
            end
            S_TURN: begin
                if (r_dneg) begin
                    if (r_sticky || r_quo > 42'h0_8000_0000) n_turn = 32'sh8000_0000;
                    else n_turn = -$signed(r_quo[31:0]);
                end else begin
                    if (r_sticky || r_quo > 42'h0_7FFF_FFFF) n_turn = 32'sh7FFF_FFFF;
                    else n_turn = $signed(r_quo[31:0]);
                end
                n_pass = 1'b0;
                n_state = S_CSET;
            end
            S_CSET: begin
                n_cfold = (c_abs > 16'sd9000);
                n_csneg = c_ang[15];
                n_cz = {1'b0, c_zp[37:6]};
                n_cx = 34'sd652032874;
                n_cy = '0;
                n_cnt = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                if (!r_cz[32]) begin
                    n_cx = r_cx - c_dx;
                    n_cy = r_cy + c_dy;
                    n_cz = r_cz - c_at;
                end else begin
                    n_cx = r_cx + c_dx;
                    n_cy = r_cy - c_dy;
                    n_cz = r_cz + c_at;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CORDIC_LAST)) n_state = S_CFIN;
            end
            S_CFIN: begin
                n_cnt = '0;
                if (!r_pass) begin
                    n_sn = c_ss;
                    n_cs = c_sc;
                    if (r_arc && (r_dl != r_dr)) begin
                        n_pass = 1'b1;
                        n_state = S_CSET;
                    end else begin
                        n_ma = {9'd0, (r_mean[32] ? 33'(-r_mean) : r_mean)};
                        n_mp = {42'd0, (c_sc[17] ? 18'(-c_sc) : c_sc)};
                        n_mneg = r_mean[32] ^ c_sc[17];
                        n_mop = MOP_SX;
                        n_state = S_MUL;
                    end
                end else begin
                    n_sp = c_ss;
                    n_cp = c_sc;
                    n_ma = {18'd0, r_wb};
                    n_mp = {42'd0, (a_sum[17] ? 18'(-a_sum) : a_sum)};
                    n_mneg = a_sum[17];
                    n_mop = MOP_NUM;
                    n_state = S_MUL;
                end
            end
            S_RTAKE: begin
                n_cnt = '0;
                n_ma = r_quo;
                n_mp = {42'd0, (s_d[18] ? 18'(-s_d) : s_d[17:0])};
                n_mneg = r_dneg ^ s_d[18];
                n_mop = MOP_RX;
                n_state = S_MUL;
            end
            S_POS: begin
                n_x = sat48({r_x[47], r_x} + 49'(r_dx));
                if (r_mop == MOP_RY) n_y = sat48({r_y[47], r_y} - 49'(r_dy));
                else n_y = sat48({r_y[47], r_y} + 49'(r_dy));
                n_prev = r_h;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_o_x = r_x;
                    n_o_y = r_y;
                    n_o_h = r_h;
                    if (r_mean > 33'sh0_7FFF_FFFF) n_o_sd = 32'sh7FFF_FFFF;
                    else if (r_mean < -33'sh0_8000_0000) n_o_sd = 32'sh8000_0000;
                    else n_o_sd = r_mean[31:0];
                    n_o_ta = r_turn;
                    n_o_lt = r_ltrav;
                    n_o_rt = r_rtrav;
                    n_o_ls = r_dl;
                    n_o_rs = r_dr;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // register writes, only made while idle
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_METERS_PER_TICK:   n_mpt = i_cfg_data;
                CFG_WHEEL_BASE:        n_wb = i_cfg_data[23:0];
                CFG_START_HEADING:     n_sh = i_cfg_data[16:0];
                CFG_ARC_MODE:          n_arc = i_cfg_data[0];
                CFG_START_LEFT_COUNT:  n_last_l = i_cfg_data[15:0];
                CFG_START_RIGHT_COUNT: n_last_r = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop <= MOP_DL;
            r_mpt <= 32'd366;
            r_wb <= 24'd15073;
            r_sh <= '0;
            r_arc <= 1'b1;
            r_last_l <= '0;
            r_last_r <= '0;
            r_prev <= '0;
            r_ltrav <= '0;
            r_rtrav <= '0;
            r_x <= '0;
            r_y <= '0;
            r_cnt <= '0;
            r_pass <= 1'b0;
            r_darc <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mop <= n_mop;
            r_mpt <= n_mpt;
            r_wb <= n_wb;
            r_sh <= n_sh;
            r_arc <= n_arc;
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
            r_prev <= n_prev;
            r_ltrav <= n_ltrav;
            r_rtrav <= n_rtrav;
            r_x <= n_x;
            r_y <= n_y;
            r_cnt <= n_cnt;
            r_pass <= n_pass;
            r_darc <= n_darc;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dl <= n_dl;  r_dr <= n_dr;  r_hneg <= n_hneg;  r_hmag <= n_hmag;  r_h <= n_h;
        r_ma <= n_ma;  r_mp <= n_mp;  r_mneg <= n_mneg;
        r_distl <= n_distl;  r_distr <= n_distr;  r_mean <= n_mean;  r_turn <= n_turn;
        r_dvd <= n_dvd;  r_dsr <= n_dsr;  r_rem <= n_rem;  r_quo <= n_quo;
        r_sticky <= n_sticky;  r_dneg <= n_dneg;
        r_cfold <= n_cfold;  r_csneg <= n_csneg;
        r_cx <= n_cx;  r_cy <= n_cy;  r_cz <= n_cz;
        r_sn <= n_sn;  r_cs <= n_cs;  r_sp <= n_sp;  r_cp <= n_cp;
        r_dx <= n_dx;  r_dy <= n_dy;
        r_o_x <= n_o_x;  r_o_y <= n_o_y;  r_o_h <= n_o_h;  r_o_sd <= n_o_sd;
        r_o_ta <= n_o_ta;  r_o_lt <= n_o_lt;  r_o_rt <= n_o_rt;
        r_o_ls <= n_o_ls;  r_o_rs <= n_o_rs;
    end

endmodule
